// ===== design/lsq_pkg.sv =====
// Package for the lap sensor qualifier: register indexes, reset values,
// button phase codes and the configuration struct. No dependencies.
`default_nettype none

package lsq_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BLINK_W    = 10;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned FIELD_LANES = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_LOCKOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_HOLD  = 2'd3;

  localparam logic [BLINK_W-1:0] BLINK_RESET   = 10'd1000;
  localparam logic [HOLD_W-1:0]  LOCKOUT_RESET = 16'd2400;
  localparam logic [HOLD_W-1:0]  HOLD_RESET    = 16'd300;

  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_HELD     = 2'd1;
  localparam logic [1:0] PH_REPORTED = 2'd2;

  typedef struct packed {
    logic               power_on;
    logic [BLINK_W-1:0] blink_period;
    logic [HOLD_W-1:0]  lane_lockout;
    logic [HOLD_W-1:0]  button_hold;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/lsq_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
// Depends on nothing.
`default_nettype none

interface lsq_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] lane_levels;
  logic       pause_level;

  modport source (output valid, lane_levels, pause_level, input ready);
  modport sink   (input valid, lane_levels, pause_level, output ready);
endinterface

interface lsq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] lane_events;
  logic       pause_event;
  logic       led_on;

  modport source (output valid, lane_events, pause_event, led_on, input ready);
  modport sink   (input valid, lane_events, pause_event, led_on, output ready);
endinterface

`default_nettype wire

// ===== design/lsq_lane.sv =====
// One lane's crossing qualifier: lockout stamp and latch.
// Depends on lsq_pkg.
`default_nettype none

module lsq_lane
  import lsq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick_en,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire cfg_t                 cfg,
  input  wire logic                 level,
  output logic                      hit
);

  logic [TIME_BITS-1:0] stamp_r, stamp_nxt;
  logic                 latched_r, latched_nxt;
  logic                 past;

  assign past = (now - stamp_r) > {{(TIME_BITS-HOLD_W){1'b0}}, cfg.lane_lockout};

  always_comb begin
    hit         = 1'b0;
    stamp_nxt   = stamp_r;
    latched_nxt = latched_r;
    if (cfg.power_on) begin
      if (level && past && !latched_r) begin
        hit         = 1'b1;
        stamp_nxt   = now;
        latched_nxt = 1'b1;
      end
      if (!level && past) begin
        latched_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r   <= '0;
      latched_r <= 1'b0;
    end else if (tick_en) begin
      stamp_r   <= stamp_nxt;
      latched_r <= latched_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsq_button.sv =====
// Pause button hold qualifier: idle / held / reported phases with a stamp.
// Depends on lsq_pkg.
`default_nettype none

module lsq_button
  import lsq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick_en,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire cfg_t                 cfg,
  input  wire logic                 pressed,
  output logic                      press_evt
);

  logic [1:0]           phase_r, phase_nxt;
  logic [TIME_BITS-1:0] stamp_r, stamp_nxt;
  logic [TIME_BITS-1:0] hold_ext;

  assign hold_ext = {{(TIME_BITS-HOLD_W){1'b0}}, cfg.button_hold};

  // Steps run in order; each sees the phase and stamp left by the one before.
  always_comb begin
    phase_nxt = phase_r;
    stamp_nxt = stamp_r;
    press_evt = 1'b0;
    if (!pressed && phase_nxt == PH_REPORTED) begin
      stamp_nxt = now;
      phase_nxt = PH_IDLE;
    end
    if (pressed && phase_nxt == PH_IDLE) begin
      phase_nxt = PH_HELD;
      stamp_nxt = now;
    end
    if (pressed && phase_nxt == PH_HELD && (now - stamp_nxt) > hold_ext) begin
      phase_nxt = PH_REPORTED;
      press_evt = 1'b1;
    end
    if (!pressed && (now - stamp_nxt) > hold_ext) begin
      phase_nxt = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      stamp_r <= '0;
    end else if (tick_en) begin
      phase_r <= phase_nxt;
      stamp_r <= stamp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsq_led.sv =====
// Status LED blinker: toggles once the period has elapsed, steady on at period 1.
// Depends on lsq_pkg.
`default_nettype none

module lsq_led
  import lsq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick_en,
  input  wire logic [TIME_BITS-1:0] now,
  input  wire cfg_t                 cfg,
  output logic                      led_nxt
);

  logic [TIME_BITS-1:0] stamp_r, stamp_nxt;
  logic                 led_r;

  always_comb begin
    stamp_nxt = stamp_r;
    led_nxt   = led_r;
    if ((now - stamp_r) > {{(TIME_BITS-BLINK_W){1'b0}}, cfg.blink_period}) begin
      stamp_nxt = now;
      led_nxt   = (cfg.blink_period == BLINK_W'(1)) ? 1'b1 : !led_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
      led_r   <= 1'b0;
    end else if (tick_en) begin
      stamp_r <= stamp_nxt;
      led_r   <= led_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lap_sensor_qualifier.sv =====
// Lap sensor qualifier: one tick item in, one result item out.
// Channels: in_ch carries one millisecond tick (lane sensor levels, pause
// button level); out_ch carries the qualified lane crossings, pause press
// and LED level for that tick. Both are valid/ready; a transfer happens on
// a rising edge with valid and ready high.
// Configuration: cfg_we/cfg_index/cfg_wdata write power_on, blink_period,
// lane_lockout and button_hold; write only while no tick is in flight.
// Latency: the result of a tick is valid the cycle after its transfer.
// Throughput: one tick per cycle while out_ch.ready is high. The tick's
// whole update (elapsed-time subtract and compare per lane, button and
// LED) runs in the cycle it is taken, straight into the output register.
// Stall: the output register holds its result while out_ch.ready is low;
// in_ch.ready follows it, so a new tick is taken in the same cycle the
// held result leaves.
// Reset (rst_n low, synchronous): tick counter, stamps, latches, button
// phase and LED cleared, registers to their defaults, output empty.
// Depends on lsq_pkg, lsq_if, lsq_lane, lsq_button, lsq_led.
`default_nettype none

module lap_sensor_qualifier
  import lsq_pkg::*;
#(
  parameter int unsigned LANE_COUNT = 4,
  parameter int unsigned TIME_BITS  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lsq_in_if.sink                     in_ch,
  lsq_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                  cfg_r;
  logic [TIME_BITS-1:0]  tick_r;
  logic                  tick_en;
  logic [LANE_COUNT-1:0] lane_hit;
  logic [FIELD_LANES-1:0] events_nxt;
  logic                  pause_nxt;
  logic                  led_nxt;

  logic                   out_valid_r;
  logic [FIELD_LANES-1:0] events_r;
  logic                   pause_r;
  logic                   led_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign tick_en     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_on     <= 1'b0;
      cfg_r.blink_period <= BLINK_RESET;
      cfg_r.lane_lockout <= LOCKOUT_RESET;
      cfg_r.button_hold  <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POWER_ON:     cfg_r.power_on     <= cfg_wdata[0];
        CFG_BLINK_PERIOD: cfg_r.blink_period <= cfg_wdata[BLINK_W-1:0];
        CFG_LANE_LOCKOUT: cfg_r.lane_lockout <= cfg_wdata[HOLD_W-1:0];
        CFG_BUTTON_HOLD:  cfg_r.button_hold  <= cfg_wdata[HOLD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (tick_en) begin
      tick_r <= tick_r + TIME_BITS'(1);
    end
  end

  for (genvar i = 0; i < LANE_COUNT; i++) begin : g_lane
    logic level;
    // lanes past the field width have no sensor and read low
    if (i < FIELD_LANES) begin : g_wired
      assign level = in_ch.lane_levels[i];
    end else begin : g_unwired
      assign level = 1'b0;
    end
    lsq_lane #(.TIME_BITS(TIME_BITS)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .tick_en (tick_en),
      .now     (tick_r),
      .cfg     (cfg_r),
      .level   (level),
      .hit     (lane_hit[i])
    );
  end

  for (genvar j = 0; j < FIELD_LANES; j++) begin : g_evt
    if (j < LANE_COUNT) begin : g_used
      assign events_nxt[j] = lane_hit[j];
    end else begin : g_none
      assign events_nxt[j] = 1'b0;
    end
  end

  lsq_button #(.TIME_BITS(TIME_BITS)) u_button (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_en   (tick_en),
    .now       (tick_r),
    .cfg       (cfg_r),
    .pressed   (in_ch.pause_level),
    .press_evt (pause_nxt)
  );

  lsq_led #(.TIME_BITS(TIME_BITS)) u_led (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .now     (tick_r),
    .cfg     (cfg_r),
    .led_nxt (led_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      events_r <= events_nxt;
      pause_r  <= pause_nxt;
      led_r    <= led_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.lane_events = events_r;
  assign out_ch.pause_event = pause_r;
  assign out_ch.led_on      = led_r;

endmodule

`default_nettype wire

// ===== design/lsq_checker.sv =====
// Port-level checks for lap_sensor_qualifier, attached by bind.
// Depends on the top level's channel and reset ports.
`default_nettype none

module lsq_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every tick transfer produces a result the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("tick transfer without result");

  // empty output stage never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // no result appears without a tick transfer
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("result without tick");

endmodule

bind lap_sensor_qualifier lsq_checker u_lsq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

// ===== tb/sv/lsq_tick_check.sv =====
`timescale 1ns / 1ps
// Result checker for lap_sensor_qualifier: watches both channels and the
// register write port, predicts each tick's result and compares in order.
// Depends on lsq_pkg and the channel interfaces in lsq_if.
module lsq_tick_check
  import lsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  lsq_in_if                     in_ch,
  lsq_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  typedef struct packed {
    logic [3:0] lane_events;
    logic       pause_event;
    logic       led_on;
  } tick_result_t;

  cfg_t         regs;
  logic [31:0]  tick_now;
  logic [31:0]  lane_stamp [4];
  logic [3:0]   lane_latched;
  logic [1:0]   button_phase;
  logic [31:0]  button_stamp;
  logic [31:0]  blink_stamp;
  logic         led_level;
  tick_result_t tick_results [$];
  int unsigned  result_idx;

  initial begin
    mismatches = 0;
    pending    = 0;
    result_idx = 0;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Advances the qualifier state by one tick and returns what it reports.
  function automatic tick_result_t predict_tick(input logic [3:0] levels,
                                                input logic pressed);
    tick_result_t r;
    logic [31:0]  age;
    int           i;
    r = '0;

    age = tick_now - blink_stamp;
    if (age > {22'd0, regs.blink_period}) begin
      blink_stamp = tick_now;
      led_level   = ~led_level;
      if (regs.blink_period == 10'd1) led_level = 1'b1;
    end

    // lanes freeze entirely while power is off
    if (regs.power_on) begin
      for (i = 0; i < 4; i++) begin
        age = tick_now - lane_stamp[i];
        if (levels[i] && age > {16'd0, regs.lane_lockout} && !lane_latched[i]) begin
          r.lane_events[i] = 1'b1;
          lane_stamp[i]    = tick_now;
          lane_latched[i]  = 1'b1;
        end else if (!levels[i] && age > {16'd0, regs.lane_lockout}) begin
          lane_latched[i] = 1'b0;
        end
      end
    end

    if (!pressed && button_phase == PH_REPORTED) begin
      button_stamp = tick_now;
      button_phase = PH_IDLE;
    end
    if (pressed && button_phase == PH_IDLE) begin
      button_phase = PH_HELD;
      button_stamp = tick_now;
    end
    age = tick_now - button_stamp;
    if (pressed && button_phase == PH_HELD && age > {16'd0, regs.button_hold}) begin
      button_phase  = PH_REPORTED;
      r.pause_event = 1'b1;
    end
    // short press: phase drops back only once the hold time has run out
    if (!pressed && age > {16'd0, regs.button_hold}) button_phase = PH_IDLE;

    r.led_on = led_level;
    tick_now = tick_now + 32'd1;
    return r;
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst_n) begin
      regs.power_on     = 1'b0;
      regs.blink_period = BLINK_RESET;
      regs.lane_lockout = LOCKOUT_RESET;
      regs.button_hold  = HOLD_RESET;
      tick_now          = '0;
      lane_stamp        = '{default: '0};
      lane_latched      = '0;
      button_phase      = PH_IDLE;
      button_stamp      = '0;
      blink_stamp       = '0;
      led_level         = 1'b0;
      tick_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POWER_ON:     regs.power_on     = cfg_wdata[0];
          CFG_BLINK_PERIOD: regs.blink_period = cfg_wdata[BLINK_W-1:0];
          CFG_LANE_LOCKOUT: regs.lane_lockout = cfg_wdata[HOLD_W-1:0];
          CFG_BUTTON_HOLD:  regs.button_hold  = cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        tick_results.push_back(predict_tick(in_ch.lane_levels, in_ch.pause_level));
      if (out_ch.valid && out_ch.ready) begin
        if (tick_results.size() == 0) begin
          report($sformatf("result %0d arrived with no tick outstanding", result_idx));
        end else begin
          want = tick_results.pop_front();
          if (out_ch.lane_events !== want.lane_events ||
              out_ch.pause_event !== want.pause_event ||
              out_ch.led_on !== want.led_on)
            report($sformatf("result %0d lanes %b/%b pause %b/%b led %b/%b (got/exp)",
                             result_idx, out_ch.lane_events, want.lane_events,
                             out_ch.pause_event, want.pause_event,
                             out_ch.led_on, want.led_on));
        end
        result_idx++;
      end
    end
    pending <= unsigned'(tick_results.size());
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Top of the lap_sensor_qualifier testbench: clock, reset, tick stimulus,
// register writes and the verdict. Depends on lsq_pkg, lsq_if, lsq_tick_check.
module tb;
  import lsq_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TICK_TARGET  = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int unsigned           mismatches;
  int unsigned           pending;
  int unsigned           ticks_sent;
  int unsigned           quiet_cycles;
  logic                  src_idle;
  logic                  snk_idle;

  lsq_in_if  in_ch ();
  lsq_out_if out_ch ();

  lap_sensor_qualifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lsq_tick_check u_tick_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // no transfer on either channel for too long means the block is stuck
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: one random stall per result, none while snk_idle is low
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = snk_idle ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_tick(input logic [3:0] levels, input logic pressed);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.lane_levels <= levels;
    in_ch.pause_level <= pressed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // hold off until every result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic pwr, input logic [9:0] blink,
                            input logic [15:0] lockout, input logic [15:0] hold);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POWER_ON;
    cfg_wdata <= {15'd0, pwr};
    @(posedge clk);
    cfg_index <= CFG_BLINK_PERIOD;
    cfg_wdata <= {6'd0, blink};
    @(posedge clk);
    cfg_index <= CFG_LANE_LOCKOUT;
    cfg_wdata <= lockout;
    @(posedge clk);
    cfg_index <= CFG_BUTTON_HOLD;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [3:0]  lv;
    logic        pb;
    logic        pwr;
    logic [9:0]  blink_v;
    logic [15:0] lock_v;
    logic [15:0] hold_v;
    int unsigned n;
    int unsigned k;

    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_POWER_ON;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.lane_levels <= '0;
    in_ch.pause_level <= 1'b0;
    src_idle          <= 1'b0;
    snk_idle          <= 1'b0;
    quiet_cycles      <= 0;
    ticks_sent        = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: power off, nothing reported, button only gets to held
    send_tick(4'hF, 1'b1);
    send_tick(4'h0, 1'b0);
    send_tick(4'hF, 1'b0);
    send_tick(4'h0, 1'b1);

    // zero lockout and hold, steady LED: report, latch, re-arm, press/release
    drain();
    src_idle <= 1'b1;
    snk_idle <= 1'b1;
    set_config(1'b1, 10'd1, 16'd0, 16'd0);
    send_tick(4'hF, 1'b0);
    send_tick(4'hF, 1'b0);
    send_tick(4'h0, 1'b1);
    send_tick(4'hF, 1'b1);
    send_tick(4'hF, 1'b1);
    send_tick(4'h0, 1'b0);
    send_tick(4'h1, 1'b1);
    send_tick(4'h2, 1'b0);
    send_tick(4'h4, 1'b0);
    send_tick(4'h8, 1'b1);

    // longest lockout and hold, LED toggling every tick: short press stays held
    drain();
    set_config(1'b1, 10'd0, 16'hFFFF, 16'hFFFF);
    send_tick(4'hF, 1'b1);
    send_tick(4'h0, 1'b0);
    send_tick(4'hF, 1'b1);
    send_tick(4'h0, 1'b1);

    // power off with short timers: lanes frozen, button still qualified
    drain();
    set_config(1'b0, 10'h3FF, 16'd3, 16'd2);
    send_tick(4'hF, 1'b1);
    send_tick(4'h0, 1'b1);
    send_tick(4'hF, 1'b1);
    send_tick(4'hF, 1'b0);

    lv = '0;
    pb = 1'b0;
    while (ticks_sent < TICK_TARGET) begin
      drain();
      src_idle <= ($urandom_range(0, 3) != 0);
      snk_idle <= ($urandom_range(0, 3) != 0);
      pwr = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
        0:       blink_v = 10'd0;
        1:       blink_v = 10'd1;
        2:       blink_v = 10'd1000;
        default: blink_v = 10'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 7))
        0:       lock_v = 16'd0;
        1:       lock_v = 16'hFFFF;
        default: lock_v = 16'($urandom_range(1, 30));
      endcase
      case ($urandom_range(0, 7))
        0:       hold_v = 16'd0;
        1:       hold_v = 16'hFFFF;
        default: hold_v = 16'($urandom_range(1, 30));
      endcase
      set_config(pwr, blink_v, lock_v, hold_v);
      n = $urandom_range(60, 250);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_tick(4'($urandom), 1'($urandom));
        end else begin
          // sensors and button change level now and then, so pulses have length
          lv = lv ^ (4'($urandom) & 4'($urandom));
          if ($urandom_range(0, 7) == 0) pb = ~pb;
          send_tick(lv, pb);
        end
      end
    end

    drain();
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/lsq_pkg.sv
design/lsq_if.sv
design/lsq_lane.sv
design/lsq_button.sv
design/lsq_led.sv
design/lap_sensor_qualifier.sv
design/lsq_checker.sv
tb/sv/lsq_tick_check.sv
tb/sv/tb.sv
